// ----- sv/skyline_rect_allocator_defines.svh -----
// Assertion macros for the skyline allocator.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef SKYLINE_RECT_ALLOCATOR_DEFINES_SVH
`define SKYLINE_RECT_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SRA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SRA_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SRA_ASSERT(lbl, prop, msg)
`define SRA_NEVER(lbl, expr, msg)
`endif
`endif

// ----- sv/sra_pkg.sv -----
// Shared types and constants of the skyline allocator.
// No dependencies.
`default_nettype none
package sra_pkg;
	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_FIT_RD, ST_FIT_EVAL,
		ST_REB_RD, ST_REB_EVAL, ST_FLUSH, ST_FIN
	} st_t;
	typedef enum logic {ACT_ALLOC = 1'b0, ACT_CLEAR = 1'b1} act_t;
	localparam logic [20:0] AREA_MAX = 21'h1FFFFF;
	localparam int SIDE_MIN = 3;
endpackage
`default_nettype wire

// ----- sv/sra_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sra_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/skyline_rect_allocator.sv -----
// Skyline rectangle allocator: top level, control and segment list banks.
// Depends on sra_pkg, sra_ram and skyline_rect_allocator_defines.svh.
`default_nettype none
`include "skyline_rect_allocator_defines.svh"
// A request is taken when start is high and busy low; its one result appears
// on placed/pos_x/pos_y/area_used with done high for a single cycle and must
// be captured then. A clear rewrites the initial segment and finishes. An
// allocation first scans every segment as a left edge, reading the list from
// RAM through a read state and an evaluate state per read; a candidate reads
// as many segments as the rectangle spans. If a place is found, the list is
// then rebuilt into the second bank and the banks swap. After reset the block
// is busy for one cycle while it writes the initial segment.
module skyline_rect_allocator
	import sra_pkg::*;
#(
	parameter int MAX_SIDE     = 1024,
	parameter int MAX_SEGMENTS = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [10:0] rect_width,
	input  wire logic [10:0] rect_height,
	output logic             done,
	output logic             placed,
	output logic [9:0]       pos_x,
	output logic [9:0]       pos_y,
	output logic [20:0]      area_used,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data
);
	localparam int MW = $clog2(MAX_SIDE) + 1;
	localparam int CW = ($clog2(MAX_SIDE) + 2 > 13) ? $clog2(MAX_SIDE) + 2 : 13;
	localparam int EW = 3 * MW;
	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int NW = $clog2(MAX_SEGMENTS) + 1;
	localparam int RST_SIDE = (1024 > MAX_SIDE) ? MAX_SIDE : 1024;
	localparam logic [NW-1:0] SEG_MAX = NW'(MAX_SEGMENTS);

	st_t st_q, st_d;
	logic cur_q, cur_d;
	logic [CW-1:0] side_q;
	logic [NW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, best_q, best_d, wp_q, wp_d;
	logic [20:0] area_q, area_d;
	logic [CW-1:0] w_q, w_d, h_q, h_d, y_q, y_d, cov_q, cov_d, bbot_q, bbot_d;
	logic [CW-1:0] by_q, by_d;
	logic [MW-1:0] cx_q, cx_d, cw_q, cw_d, bw_q, bw_d, bx_q, bx_d;
	logic found_q, found_d, trim_q, trim_d, newdone_q, newdone_d, ok_q, ok_d;
	logic pv_q, pv_d;
	logic [MW-1:0] px_q, px_d, pt_q, pt_d, pw_q, pw_d;
	logic [21:0] prod_q, prod_d;
	logic done_q, done_d, placed_q, placed_d;
	logic [9:0] posx_q, posx_d, posy_q, posy_d;

	logic we, wbank;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rd0, rd1, rdata;
	logic [MW-1:0] dx, dt, dw;
	logic [CW-1:0] limit, endv, ybase, ynew, covn, bottom, shrink, cfg_ext;
	logic [MW-1:0] cwid, cxx;
	logic first;
	logic e_v;
	logic [MW-1:0] e_x, e_t, e_w;
	logic [22:0] asum;

	function automatic logic [CW-1:0] ext(input logic [MW-1:0] v);
		ext = {{(CW-MW){1'b0}}, v};
	endfunction

	sra_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_bank0 (
		.clk(clk), .we(we && !wbank), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd0)
	);
	sra_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_bank1 (
		.clk(clk), .we(we && wbank), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd1)
	);

	assign rdata = cur_q ? rd1 : rd0;
	assign dx = rdata[EW-1:2*MW];
	assign dt = rdata[2*MW-1:MW];
	assign dw = rdata[MW-1:0];
	assign raddr = (st_q == ST_REB_RD) ? i_q[AW-1:0] : j_q[AW-1:0];
	assign limit = side_q - CW'(1);
	assign endv = ext(bx_q) + w_q;
	assign first = (j_q == i_q);
	assign ybase = first ? ext(dt) : y_q;
	assign ynew = (ext(dt) > ybase) ? ext(dt) : ybase;
	assign covn = (first ? '0 : cov_q) + ext(dw);
	assign bottom = ynew + h_q;
	assign cwid = first ? dw : cw_q;
	assign cxx = first ? dx : cx_q;
	assign shrink = endv - ext(dx);
	assign asum = {2'b0, area_q} + {1'b0, prod_q};
	assign cfg_ext = {{(CW-11){1'b0}}, cfg_data};

	assign busy = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign placed = placed_q;
	assign pos_x = posx_q;
	assign pos_y = posy_q;
	assign area_used = area_q;

	always_comb begin
		st_d = st_q; cur_d = cur_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q;
		best_d = best_q; wp_d = wp_q; area_d = area_q; w_d = w_q; h_d = h_q;
		y_d = y_q; cov_d = cov_q; bbot_d = bbot_q; by_d = by_q; cx_d = cx_q;
		cw_d = cw_q; bw_d = bw_q; bx_d = bx_q; found_d = found_q; trim_d = trim_q;
		newdone_d = newdone_q; ok_d = ok_q; pv_d = pv_q; px_d = px_q; pt_d = pt_q;
		pw_d = pw_q; prod_d = prod_q; done_d = 1'b0; placed_d = placed_q;
		posx_d = posx_q; posy_d = posy_q;
		we = 1'b0; wbank = cur_q; waddr = '0; wdata = '0;
		e_v = 1'b0; e_x = '0; e_t = '0; e_w = '0;
		unique case (st_q)
			ST_INIT: begin
				we = 1'b1;
				wdata = {MW'(1), MW'(1), MW'(RST_SIDE - 2)};
				cnt_d = NW'(1);
				st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					w_d = {{(CW-11){1'b0}}, rect_width};
					h_d = {{(CW-11){1'b0}}, rect_height};
					ok_d = 1'b0;
					if (action == ACT_CLEAR) begin
						we = 1'b1;
						wdata = {MW'(1), MW'(1), MW'(side_q - CW'(2))};
						cnt_d = NW'(1);
						st_d = ST_FIN;
					end else if (rect_width == 11'd0 || cnt_q >= SEG_MAX) begin
						st_d = ST_FIN;
					end else begin
						i_d = '0; j_d = '0; found_d = 1'b0;
						st_d = ST_FIT_RD;
					end
				end
			end
			ST_FIT_RD: begin
				if (i_q == cnt_q) begin
					if (found_q) begin
						i_d = '0; trim_d = 1'b0; newdone_d = 1'b0; pv_d = 1'b0; wp_d = '0;
						st_d = ST_REB_RD;
					end else begin
						st_d = ST_FIN;
					end
				end else if (j_q >= cnt_q) begin
					i_d = i_q + NW'(1); j_d = i_q + NW'(1);
				end else begin
					st_d = ST_FIT_EVAL;
				end
			end
			ST_FIT_EVAL: begin
				st_d = ST_FIT_RD;
				if ((first && ext(dx) + w_q > limit) || bottom > limit) begin
					i_d = i_q + NW'(1); j_d = i_q + NW'(1);
				end else if (covn >= w_q) begin
					if (!found_q || bottom < bbot_q || (bottom == bbot_q && cwid < bw_q)) begin
						found_d = 1'b1; best_d = i_q; bbot_d = bottom;
						bw_d = cwid; bx_d = cxx; by_d = ynew;
					end
					i_d = i_q + NW'(1); j_d = i_q + NW'(1);
				end else begin
					y_d = ynew; cov_d = covn; j_d = j_q + NW'(1);
					if (first) begin
						cx_d = dx; cw_d = dw;
					end
				end
			end
			ST_REB_RD: begin
				if (i_q == cnt_q) begin
					st_d = ST_FLUSH;
				end else if (i_q == best_q && !newdone_q) begin
					e_v = 1'b1; e_x = bx_q; e_t = MW'(by_q + h_q); e_w = MW'(w_q);
					newdone_d = 1'b1; trim_d = 1'b1;
				end else begin
					st_d = ST_REB_EVAL;
				end
			end
			ST_REB_EVAL: begin
				st_d = ST_REB_RD;
				i_d = i_q + NW'(1);
				if (!trim_q || ext(dx) >= endv) begin
					trim_d = 1'b0;
					e_v = 1'b1; e_x = dx; e_t = dt; e_w = dw;
				end else if (ext(dw) > shrink) begin
					trim_d = 1'b0;
					e_v = 1'b1; e_x = MW'(endv); e_t = dt; e_w = MW'(ext(dw) - shrink);
				end
			end
			ST_FLUSH: begin
				if (pv_q) begin
					we = 1'b1; wbank = !cur_q; waddr = wp_q[AW-1:0];
					wdata = {px_q, pt_q, pw_q};
				end
				cnt_d = wp_q + NW'(pv_q);
				cur_d = !cur_q;
				prod_d = w_q[10:0] * h_q[10:0];
				ok_d = 1'b1;
				st_d = ST_FIN;
			end
			ST_FIN: begin
				done_d = 1'b1;
				placed_d = ok_q;
				posx_d = ok_q ? bx_q[9:0] : 10'd0;
				posy_d = ok_q ? by_q[9:0] : 10'd0;
				if (ok_q) begin
					area_d = (asum > {2'b0, AREA_MAX}) ? AREA_MAX : asum[20:0];
				end
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
		if (e_v) begin
			if (pv_q && pt_q == e_t) begin
				pw_d = pw_q + e_w;
			end else begin
				if (pv_q) begin
					we = 1'b1; wbank = !cur_q; waddr = wp_q[AW-1:0];
					wdata = {px_q, pt_q, pw_q};
					wp_d = wp_q + NW'(1);
				end
				px_d = e_x; pt_d = e_t; pw_d = e_w; pv_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_INIT;
			cur_q <= 1'b0;
			cnt_q <= NW'(1);
			area_q <= '0;
			side_q <= CW'(RST_SIDE);
			done_q <= 1'b0;
			found_q <= 1'b0;
			trim_q <= 1'b0;
			newdone_q <= 1'b0;
			ok_q <= 1'b0;
			pv_q <= 1'b0;
			wp_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			st_q <= st_d;
			cur_q <= cur_d;
			cnt_q <= cnt_d;
			area_q <= area_d;
			done_q <= done_d;
			found_q <= found_d;
			trim_q <= trim_d;
			newdone_q <= newdone_d;
			ok_q <= ok_d;
			pv_q <= pv_d;
			wp_q <= wp_d;
			i_q <= i_d;
			j_q <= j_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_ext < CW'(SIDE_MIN)) begin
					side_q <= CW'(SIDE_MIN);
				end else if (cfg_ext > CW'(MAX_SIDE)) begin
					side_q <= CW'(MAX_SIDE);
				end else begin
					side_q <= cfg_ext;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		w_q <= w_d; h_q <= h_d; y_q <= y_d; cov_q <= cov_d; bbot_q <= bbot_d;
		by_q <= by_d; cx_q <= cx_d; cw_q <= cw_d; bw_q <= bw_d; bx_q <= bx_d;
		best_q <= best_d; px_q <= px_d; pt_q <= pt_d; pw_q <= pw_d;
		prod_q <= prod_d; placed_q <= placed_d; posx_q <= posx_d; posy_q <= posy_d;
	end

	`SRA_NEVER(a_cnt_range, cnt_q == '0 || cnt_q > SEG_MAX, "segment count out of range")
	`SRA_ASSERT(a_take_busy, start && !busy |=> busy, "request accepted without going busy")
	`SRA_ASSERT(a_done_after, done |-> $past(st_q) == ST_FIN, "result strobe without finish")
	`SRA_ASSERT(a_placed_done, placed && !done |-> $stable(placed), "placed changed off strobe")
endmodule
`default_nettype wire
